@@ design/rtpd_pkg.sv @@
`timescale 1ns / 1ps

package rtpd_pkg;

  // First byte of an interleaved ("$") header.
  localparam logic [7:0] DollarByte = 8'h24;

  // Top two bits of the first body byte for RTP version 2.
  localparam logic [1:0] RtpVersion2 = 2'b10;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LengthW = 16;

  // Latched framing codes as shown on framing_kind.
  typedef enum logic [1:0] {
    FRAMING_UNKNOWN = 2'd0,
    FRAMING_LEN2    = 2'd1,
    FRAMING_DOLLAR  = 2'd2
  } framing_e;

  // Parser phase. The two codes left over are treated as the header phase.
  typedef enum logic [2:0] {
    PH_HDR0  = 3'd0,
    PH_CHAN  = 3'd1,
    PH_LENHI = 3'd2,
    PH_LENLO = 3'd3,
    PH_BODY0 = 3'd4,
    PH_BODYN = 3'd5
  } phase_e;

  // One result from the parser for the current byte.
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
    logic             first;
    logic             last;
    framing_e         framing;
  } result_t;

endpackage

@@ design/rtpd_parser.sv @@
`timescale 1ns / 1ps

module rtpd_parser
  import rtpd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [ByteW-1:0] byte_i,
  output result_t          result_o
);

  phase_e               phase_q, phase_d;
  logic [ByteW-1:0]     len_hi_q, len_hi_d;
  logic [LengthW-1:0]   remain_q, remain_d;
  logic                 accept_q, accept_d;
  framing_e             framing_q, framing_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR0;
      len_hi_q  <= '0;
      remain_q  <= '0;
      accept_q  <= 1'b0;
      framing_q <= FRAMING_UNKNOWN;
    end else if (take_i) begin
      phase_q   <= phase_d;
      len_hi_q  <= len_hi_d;
      remain_q  <= remain_d;
      accept_q  <= accept_d;
      framing_q <= framing_d;
    end
  end

  always_comb begin
    phase_d   = phase_q;
    len_hi_d  = len_hi_q;
    remain_d  = remain_q;
    accept_d  = accept_q;
    framing_d = framing_q;

    result_o         = '0;
    result_o.data    = byte_i;
    result_o.framing = framing_q;

    unique case (phase_q)
      PH_CHAN: begin
        // The channel number is not used.
        phase_d = PH_LENHI;
      end
      PH_LENHI: begin
        len_hi_d = byte_i;
        phase_d  = PH_LENLO;
      end
      PH_LENLO: begin
        remain_d = {len_hi_q, byte_i};
        phase_d  = ({len_hi_q, byte_i} == '0) ? PH_HDR0 : PH_BODY0;
      end
      PH_BODY0, PH_BODYN: begin
        // The version check on the first body byte decides the whole body.
        if (phase_q == PH_BODY0) begin
          accept_d = (byte_i[ByteW-1 -: 2] == RtpVersion2);
        end
        result_o.valid = accept_d;
        result_o.first = (phase_q == PH_BODY0);
        result_o.last  = (remain_q == LengthW'(1));
        remain_d       = remain_q - LengthW'(1);
        phase_d        = (remain_q == LengthW'(1)) ? PH_HDR0 : PH_BODYN;
      end
      default: begin
        if (byte_i == DollarByte) begin
          if (framing_q == FRAMING_UNKNOWN) begin
            framing_d = FRAMING_DOLLAR;
          end
          phase_d = PH_CHAN;
        end else begin
          if (framing_q == FRAMING_UNKNOWN) begin
            framing_d = FRAMING_LEN2;
          end
          len_hi_d = byte_i;
          phase_d  = PH_LENLO;
        end
      end
    endcase
  end

endmodule

@@ design/rtp_over_tcp_deframer_top.sv @@
`timescale 1ns / 1ps

// RTP-over-TCP deframer.
// The input channel (in_valid_i / in_ready_o / stream_byte_i) carries the TCP
// byte stream, one byte per transfer. Each frame starts with either a two-byte
// big-endian length or a four-byte interleaved header ('$', channel, length).
// The header form of the first frame is latched and shown on framing_kind_o.
// The output channel (out_valid_o / out_ready_i) carries the bodies of frames
// whose first byte marks RTP version 2, one byte per transfer, with first and
// last flags. Header bytes, empty frames and other bodies give no transfer.
// A body byte taken on the input is registered and offered on the output in
// the next cycle. Throughput is one byte per cycle while the receiver keeps
// up; the parser state and the one output register are the only storage, so
// the next byte can be taken while the previous result is being handed over.
// When the receiver stalls, the output register holds its byte and in_ready_o
// drops until that byte is taken; no byte is lost or repeated.
// Reset clears the parser to expect a header and the framing to unknown, and
// empties the output register.

module rtp_over_tcp_deframer_top
  import rtpd_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] stream_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] packet_byte_o,
  output logic             first_of_packet_o,
  output logic             last_of_packet_o,
  output logic [1:0]       framing_kind_o
);

  logic    in_xfer;
  result_t result;

  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] data_q;
  logic             first_q;
  logic             last_q;
  framing_e         framing_q;

  // The output register can take a new result when it is empty or when its
  // current content leaves in this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  rtpd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .take_i   (in_xfer),
    .byte_i   (stream_byte_i),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) begin
      out_valid_d = result.valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Payload is loaded only with a real result, so a stalled byte stays put.
  always_ff @(posedge clk_i) begin
    if (in_xfer && result.valid) begin
      data_q    <= result.data;
      first_q   <= result.first;
      last_q    <= result.last;
      framing_q <= result.framing;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign packet_byte_o     = data_q;
  assign first_of_packet_o = first_q;
  assign last_of_packet_o  = last_q;
  assign framing_kind_o    = framing_q;

endmodule

@@ design/rtpd_checker.sv @@
`timescale 1ns / 1ps

module rtpd_checker
  import rtpd_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [ByteW-1:0] packet_byte_o,
  input logic             first_of_packet_o,
  input logic             last_of_packet_o,
  input logic [1:0]       framing_kind_o
);

  // A body byte always follows a header, so the framing is known on output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (framing_kind_o == FRAMING_LEN2 || framing_kind_o == FRAMING_DOLLAR))
    else $error("output framing kind is not a known header form");

  // Input is held off only by a pending output that is not being taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without an output stall");

  // A new output appears only as the result of an input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o))
    else $error("output appeared without an input transfer");

  // A stalled output keeps its byte and flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(packet_byte_o) && $stable(first_of_packet_o)
       && $stable(last_of_packet_o) && $stable(framing_kind_o)))
    else $error("stalled output changed");

  // The framing kind on consecutive outputs never changes once latched.
  logic       seen_q;
  logic [1:0] kind_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
      kind_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      seen_q <= 1'b1;
      kind_q <= framing_kind_o;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && seen_q) |-> (framing_kind_o == kind_q))
    else $error("latched framing kind changed between packets");

endmodule

bind rtp_over_tcp_deframer_top rtpd_checker u_rtpd_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .packet_byte_o     (packet_byte_o),
  .first_of_packet_o (first_of_packet_o),
  .last_of_packet_o  (last_of_packet_o),
  .framing_kind_o    (framing_kind_o)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the RTP-over-TCP deframer. A byte stream of framed
// packets (both header forms, empty frames, non-RTP bodies, broken headers and
// one frame with both length bytes set) is pushed through the input channel.
// Every byte that is taken is run through a local deframer model, and the body
// bytes it predicts are checked in order against the output transfers.

module tb_top;
  import rtpd_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned PhaseBytes = 600;

  // Parser state, kept once for the stream generator and once for the checker.
  typedef struct {
    phase_e      phase;
    logic        dollar_frame;
    logic [7:0]  len_hi;
    logic [15:0] remaining;
    logic        passing;
    framing_e    framing;
  } deframe_state_t;

  // One body byte as it should appear on the output channel.
  typedef struct {
    logic [7:0] byte_val;
    logic       sop;
    logic       eop;
    framing_e   framing;
  } rtp_byte_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [ByteW-1:0] stream_byte_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [ByteW-1:0] packet_byte_o;
  logic             first_of_packet_o;
  logic             last_of_packet_o;
  logic [1:0]       framing_kind_o;

  logic [7:0]     stream_q[$];
  rtp_byte_t      expected_q[$];
  deframe_state_t gen_st;
  deframe_state_t dut_st;
  int unsigned    gen_total;
  int unsigned    tx_idle_pct;
  int unsigned    rx_idle_pct;
  int unsigned    error_count;
  int unsigned    out_count;
  int unsigned    stall_cycles;
  int unsigned    hold_left;
  int unsigned    holds_done;
  logic           in_took;

  rtp_over_tcp_deframer_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .stream_byte_i    (stream_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .packet_byte_o    (packet_byte_o),
    .first_of_packet_o(first_of_packet_o),
    .last_of_packet_o (last_of_packet_o),
    .framing_kind_o   (framing_kind_o)
  );

  function automatic deframe_state_t deframe_reset();
    deframe_state_t st;
    st.phase        = PH_HDR0;
    st.dollar_frame = 1'b0;
    st.len_hi       = '0;
    st.remaining    = '0;
    st.passing      = 1'b0;
    st.framing      = FRAMING_UNKNOWN;
    return st;
  endfunction

  // Advances the parser by one stream byte; returns 1 when a body byte is
  // passed on, with its marks in res.
  function automatic bit deframe_step(inout deframe_state_t st, input logic [7:0] b,
                                      output rtp_byte_t res);
    bit emitted;
    emitted  = 1'b0;
    res.sop  = 1'b0;
    res.eop  = 1'b0;
    case (st.phase)
      PH_CHAN: st.phase = PH_LENHI;
      PH_LENHI: begin
        st.len_hi = b;
        st.phase  = PH_LENLO;
      end
      PH_LENLO: begin
        st.remaining = {st.len_hi, b};
        st.phase     = (st.remaining == 16'd0) ? PH_HDR0 : PH_BODY0;
      end
      PH_BODY0, PH_BODYN: begin
        // The version check is made on the first body byte and holds for
        // the whole frame.
        if (st.phase == PH_BODY0) st.passing = (b[7:6] == RtpVersion2);
        if (st.passing) begin
          emitted = 1'b1;
          res.sop = (st.phase == PH_BODY0);
          res.eop = (st.remaining == 16'd1);
        end
        st.remaining = st.remaining - 16'd1;
        st.phase     = (st.remaining == 16'd0) ? PH_HDR0 : PH_BODYN;
      end
      default: begin
        // Header start. Only the very first header sets the framing.
        if (b == DollarByte) begin
          st.dollar_frame = 1'b1;
          if (st.framing == FRAMING_UNKNOWN) st.framing = FRAMING_DOLLAR;
          st.phase = PH_CHAN;
        end else begin
          st.dollar_frame = 1'b0;
          if (st.framing == FRAMING_UNKNOWN) st.framing = FRAMING_LEN2;
          st.len_hi = b;
          st.phase  = PH_LENLO;
        end
      end
    endcase
    res.byte_val = b;
    res.framing  = st.framing;
    return emitted;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("%0t: mismatch: %s", $time, msg);
  endtask

  task automatic put_byte(input logic [7:0] b);
    rtp_byte_t discard;
    stream_q.push_back(b);
    gen_total++;
    void'(deframe_step(gen_st, b, discard));
  endtask

  task automatic put_frame(input bit dollar, input logic [7:0] chan,
                           input int unsigned len, input logic [7:0] lead);
    if (dollar) begin
      put_byte(DollarByte);
      put_byte(chan);
    end
    put_byte(len[15:8]);
    put_byte(len[7:0]);
    for (int unsigned i = 0; i < len; i++) put_byte((i == 0) ? lead : 8'($urandom));
  endtask

  // Random bytes dropped into the stream, then random filler until the parser
  // is back at a header. Length high bytes are kept small so that a broken
  // header cannot swallow the rest of the run.
  task automatic put_noise(input int unsigned n);
    logic [7:0]  b;
    int unsigned pick;
    for (int unsigned i = 0; i < n; i++) begin
      b = 8'($urandom);
      if (gen_st.phase == PH_HDR0) begin
        pick = $urandom_range(2);
        b = (pick == 0) ? DollarByte : 8'(pick - 1);
      end else if (gen_st.phase == PH_LENHI) begin
        b[7:1] = '0;
      end
      put_byte(b);
    end
    while (gen_st.phase != PH_HDR0) begin
      b = 8'($urandom);
      if (gen_st.phase == PH_LENHI) b[7:1] = '0;
      put_byte(b);
    end
  endtask

  task automatic fill_random(input int unsigned n_bytes);
    int unsigned start;
    int unsigned sel;
    int unsigned len;
    int unsigned v;
    logic [7:0]  lead;
    start = gen_total;
    while (gen_total - start < n_bytes) begin
      if ($urandom_range(99) < 10) begin
        put_noise($urandom_range(1, 6));
      end else begin
        sel = $urandom_range(99);
        if (sel < 5) len = 0;
        else if (sel < 85) len = $urandom_range(1, 12);
        else len = $urandom_range(13, 300);
        lead = 8'($urandom);
        if ($urandom_range(3) != 0) begin
          lead[7:6] = RtpVersion2;
        end else begin
          v = $urandom_range(2);
          lead[7:6] = (v == 2) ? 2'b11 : 2'(v);
        end
        put_frame($urandom_range(1), 8'($urandom), len, lead);
      end
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Sender: a new byte is offered only once the previous one was taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_took) begin
        if (stream_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid_i    <= 1'b1;
          stream_byte_i <= stream_q[0];
          stream_q.delete(0);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random back-pressure, plus two long hold-offs that let the
  // output register fill and stall the input side.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left == 0 && holds_done < 2 &&
          out_count >= ((holds_done == 0) ? 150 : 1000)) begin
        hold_left = HoldCycles;
        holds_done++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Checker: output transfers are compared first, then the byte taken at this
  // edge is run through the model, since its result can only come later.
  always @(posedge clk_i) begin : monitor
    rtp_byte_t want;
    rtp_byte_t nxt;
    if (rst_ni) begin
      in_took <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) begin
        out_count++;
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("packet byte %02h with nothing expected", packet_byte_o));
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          if (packet_byte_o !== want.byte_val)
            report_mismatch($sformatf("packet_byte %02h, expected %02h",
                                      packet_byte_o, want.byte_val));
          if (first_of_packet_o !== want.sop)
            report_mismatch($sformatf("first_of_packet %b, expected %b",
                                      first_of_packet_o, want.sop));
          if (last_of_packet_o !== want.eop)
            report_mismatch($sformatf("last_of_packet %b, expected %b",
                                      last_of_packet_o, want.eop));
          if (framing_kind_o !== want.framing)
            report_mismatch($sformatf("framing_kind %0d, expected %0d",
                                      framing_kind_o, want.framing));
        end
      end
      if (in_valid_i && in_ready_o) begin
        if (deframe_step(dut_st, stream_byte_i, nxt)) expected_q.push_back(nxt);
      end
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    stream_byte_i = '0;
    out_ready_i   = 1'b0;
    in_took       = 1'b0;
    gen_total     = 0;
    error_count   = 0;
    out_count     = 0;
    stall_cycles  = 0;
    hold_left     = 0;
    holds_done    = 0;
    gen_st        = deframe_reset();
    dut_st        = deframe_reset();

    // First phase: sender mostly busy, receiver often stalled.
    tx_idle_pct = 7;
    rx_idle_pct = 57;

    // The opening frame picks the framing for the whole run; it is a single
    // byte packet, so first and last are both set.
    put_frame($urandom_range(1), 8'h00, 1, 8'h80);
    // Empty frames of both forms produce nothing.
    put_frame(1'b0, 8'h00, 0, 8'h00);
    put_frame(1'b1, 8'hFF, 0, 8'h00);
    // Bodies that are not RTP version 2 are dropped; the lead BF of the third is version 2, so it passes.
    put_frame(1'b0, 8'h00, 1, 8'h40);
    put_frame(1'b1, 8'h00, 1, 8'hC0);
    put_frame(1'b0, 8'h00, 3, 8'hBF);
    // A two-byte length whose high byte is the dollar sign is read as an
    // interleaved header: channel 05, length 2.
    put_byte(DollarByte);
    put_byte(8'h05);
    put_byte(8'h00);
    put_byte(8'h02);
    put_byte(8'h80);
    put_byte(8'hFF);
    fill_random(PhaseBytes);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (stream_q.size() != 0) @(posedge clk_i);
    tx_idle_pct = 57;
    rx_idle_pct = 7;
    fill_random(PhaseBytes);

    while (stream_q.size() != 0) @(posedge clk_i);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    fill_random(PhaseBytes / 2);
    // One frame with both length bytes set, longer than any random frame.
    put_frame(1'b0, 8'h00, 16'h0181, {RtpVersion2, 6'($urandom)});
    fill_random(PhaseBytes / 2);

    while (stream_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
